// File: rtl/fvs_pkg.sv
// Shared types and constants for the frame variance voice segmenter.
// No dependencies.
package fvs_pkg;
	localparam int RING_W = 14;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W = 41;

	localparam logic [1:0] REG_FRAME_LEN = 2'd0;
	localparam logic [1:0] REG_VAR_LIMIT = 2'd1;
	localparam logic [1:0] REG_MIN_SPAN = 2'd2;
	localparam logic [1:0] REG_HANGOVER = 2'd3;

	typedef struct packed {
		logic accept;     // sample beat taken
		logic div_start;  // frame closes on this beat
		logic div_step;
		logic rd_en;      // variance pass read
		logic finish;     // segment update, result load
	} fvs_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic div_done;
		logic rd_done;
		logic pipe_empty;
		logic out_free;
	} fvs_stat_t;
endpackage

// File: rtl/fvs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module fvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: rtl/fvs_ctrl.sv
// Sequencer: collect, divide, variance pass, drain, finish.
// Depends on fvs_pkg.
module fvs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  fvs_pkg::fvs_stat_t stat,
	output fvs_pkg::fvs_cmd_t  cmd
);
	import fvs_pkg::*;

	typedef enum logic [4:0] {
		ST_COLLECT = 5'b00001,
		ST_DIVIDE  = 5'b00010,
		ST_PASS    = 5'b00100,
		ST_DRAIN   = 5'b01000,
		ST_FINISH  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_COLLECT: begin
				sample_stall = 1'b0;
				cmd.accept = sample_valid;
				cmd.div_start = sample_valid & stat.frame_end;
				if (sample_valid && stat.frame_end) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_PASS;
				end
			end
			ST_PASS: begin
				cmd.rd_en = 1'b1;
				if (stat.rd_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_empty) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: rtl/fvs_dp.sv
// Datapath: frame store, statistics, mean divider, variance MAC,
// segmenter state, config registers and result register. Uses fvs_pkg, fvs_ram.
module fvs_dp #(
	parameter int MAX_FRAME = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fvs_pkg::fvs_cmd_t             cmd,
	output fvs_pkg::fvs_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [fvs_pkg::CFG_W-1:0]     cfg_data,
	input  logic signed [fvs_pkg::SAMPLE_W-1:0] sample,
	input  logic                          result_stall,
	output logic                          result_valid,
	output logic [13:0]                   frame_number,
	output logic [25:0]                   magnitude_sum,
	output logic [15:0]                   peak_to_peak,
	output logic [40:0]                   frame_variance,
	output logic                          segment_ready,
	output logic [13:0]                   segment_first,
	output logic [13:0]                   segment_end
);
	import fvs_pkg::*;

	localparam int CW = $clog2(MAX_FRAME);
	localparam int NW = CW + 1;
	localparam int LW = (NW > 11) ? NW : 11;
	localparam int AW = SAMPLE_W + CW;
	localparam int VW = 2 * SAMPLE_W - 1 + CW;
	localparam int DCW = $clog2(AW);

	// config
	logic [10:0]       frame_len_q;
	logic [40:0]       var_limit_q;
	logic [RING_W-1:0] min_span_q;
	logic [5:0]        hangover_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= 11'd320;
			var_limit_q <= 41'd4000000;
			min_span_q <= 14'd5;
			hangover_q <= 6'd20;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_LEN: frame_len_q <= cfg_data[10:0];
				REG_VAR_LIMIT: var_limit_q <= cfg_data[40:0];
				REG_MIN_SPAN:  min_span_q <= cfg_data[13:0];
				REG_HANGOVER:  hangover_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// collection
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_cur, n_q;
	logic [LW-1:0] len_eff;
	logic [SAMPLE_W-1:0] mag_in;
	logic [AW-1:0] abs_q, abs_nxt;
	logic signed [SAMPLE_W-1:0] largest_q, smallest_q;

	always_comb begin
		n_cur = {1'b0, cnt_q} + NW'(1);
		if (frame_len_q == 11'd0) begin
			len_eff = LW'(1);
		end else if (LW'(frame_len_q) > LW'(MAX_FRAME)) begin
			len_eff = LW'(MAX_FRAME);
		end else begin
			len_eff = LW'(frame_len_q);
		end
		mag_in = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
		abs_nxt = ((cnt_q == '0) ? '0 : abs_q) + AW'(mag_in);
	end
	assign stat.frame_end = LW'(n_cur) >= len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.accept) begin
			cnt_q <= stat.frame_end ? '0 : n_cur[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			abs_q <= abs_nxt;
			if (cnt_q == '0 || sample > largest_q) largest_q <= sample;
			if (cnt_q == '0 || sample < smallest_q) smallest_q <= sample;
			if (stat.frame_end) n_q <= n_cur;
		end
	end

	// mean divider, restoring, one quotient bit per cycle; quotient shifts into dvd_q
	logic [AW-1:0]  dvd_q;
	logic [NW-1:0]  rem_q;
	logic [NW:0]    rem_t;
	logic [DCW-1:0] div_cnt_q;
	logic           q_bit;

	always_comb begin
		rem_t = {rem_q, dvd_q[AW-1]};
		q_bit = rem_t >= {1'b0, n_q};
	end
	assign stat.div_done = div_cnt_q == DCW'(AW - 1);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= abs_nxt;
			rem_q <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[AW-2:0], q_bit};
			rem_q <= q_bit ? NW'(rem_t - {1'b0, n_q}) : rem_t[NW-1:0];
			div_cnt_q <= div_cnt_q + DCW'(1);
		end
	end

	// frame store
	logic [CW-1:0]       rd_ptr_q;
	logic [SAMPLE_W-1:0] rdata;

	fvs_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_FRAME)) u_store (
		.clk   (clk),
		.we    (cmd.accept),
		.addr  (cmd.accept ? cnt_q : rd_ptr_q),
		.wdata (sample),
		.rdata (rdata)
	);

	assign stat.rd_done = {1'b0, rd_ptr_q} == n_q - NW'(1);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rd_ptr_q <= '0;
		end else if (cmd.rd_en) begin
			rd_ptr_q <= rd_ptr_q + CW'(1);
		end
	end

	// variance MAC: read, square, accumulate
	logic v_s1, v_s2;
	logic [SAMPLE_W-1:0] mag_rd;
	logic signed [SAMPLE_W:0] dev;
	logic [2*SAMPLE_W-1:0] sq_s2;
	logic [VW-1:0] acc_q;

	always_comb begin
		mag_rd = rdata[SAMPLE_W-1] ? SAMPLE_W'(-$signed(rdata)) : rdata;
		dev = $signed({1'b0, mag_rd}) - $signed({1'b0, dvd_q[SAMPLE_W-1:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end
	assign stat.pipe_empty = !v_s1 && !v_s2;

	always_ff @(posedge clk) begin
		sq_s2 <= (2*SAMPLE_W)'(dev * dev);
		if (cmd.div_start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + VW'(sq_s2);
		end
	end

	// segmenter
	logic [RING_W-1:0] ring_q, open_s_q, held_f_q, held_l_q;
	logic              open_v_q, held_v_q;
	logic signed [6:0] cd_q;
	logic [RING_W-1:0] open_s_d, held_f_d, held_l_d, st, span, seg_f, seg_e;
	logic              open_v_d, held_v_d, ready;
	logic signed [6:0] cd_d;

	always_comb begin
		open_s_d = open_s_q;
		open_v_d = open_v_q;
		held_f_d = held_f_q;
		held_l_d = held_l_q;
		held_v_d = held_v_q;
		cd_d = cd_q;
		ready = 1'b0;
		seg_f = '0;
		seg_e = '0;
		st = open_v_q ? open_s_q : '1;
		span = ring_q - st;
		if (64'(acc_q) > 64'(var_limit_q)) begin
			if (!open_v_q) begin
				open_s_d = ring_q;
				open_v_d = 1'b1;
			end
		end else begin
			if ((open_v_q || held_v_q) && span >= min_span_q) begin
				if (!held_v_q) begin
					held_f_d = open_s_q;
					held_l_d = ring_q;
					held_v_d = 1'b1;
					cd_d = 7'($unsigned(hangover_q));
					open_v_d = 1'b0;
				end else if (cd_q > 7'sd0 && open_v_q) begin
					held_l_d = ring_q;
					open_v_d = 1'b0;
					cd_d = 7'($unsigned(hangover_q));
				end
				if (cd_d == 7'sd0) begin
					ready = 1'b1;
					seg_f = held_f_d;
					seg_e = held_l_d;
					held_v_d = 1'b0;
					held_f_d = '0;
					held_l_d = '0;
				end
			end
			if (cd_d >= 7'sd0) cd_d = cd_d - 7'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
			open_s_q <= '0;
			open_v_q <= 1'b0;
			held_f_q <= '0;
			held_l_q <= '0;
			held_v_q <= 1'b0;
			cd_q <= -7'sd1;
		end else if (cmd.finish) begin
			ring_q <= ring_q + RING_W'(1);
			open_s_q <= open_s_d;
			open_v_q <= open_v_d;
			held_f_q <= held_f_d;
			held_l_q <= held_l_d;
			held_v_q <= held_v_d;
			cd_q <= cd_d;
		end
	end

	// result register
	logic valid_q;
	assign stat.out_free = !valid_q || !result_stall;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.finish) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			frame_number <= ring_q;
			magnitude_sum <= 26'(abs_q);
			peak_to_peak <= 16'(largest_q - smallest_q);
			frame_variance <= 41'(acc_q);
			segment_ready <= ready;
			segment_first <= seg_f;
			segment_end <= seg_e;
		end
	end
endmodule

// File: rtl/frame_variance_voice_segmenter.sv
// Top level of the frame variance voice segmenter.
// Uses fvs_pkg, fvs_ctrl, fvs_dp (which holds fvs_ram).
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  sample   | sample_valid/sample_stall  | sample
//  result   | result_valid/result_stall  | frame_number .. segment_end
//  config   | cfg_we                     | cfg_index, cfg_data
//
// One sample per cycle while a frame fills. The last sample of a frame starts
// the per-frame work: a divider pass over AW (= 16 + log2 MAX_FRAME) quotient
// bits, a read of all n samples through the frame store port, a drain of the
// v_s1/v_s2 MAC stages and a finish step. Sample input stalls during that work
// and while a previous result still waits in the output register at finish.
// Reset is asynchronous and needs no clearing pass.
module frame_variance_voice_segmenter #(
	parameter int MAX_FRAME = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [fvs_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  logic signed [fvs_pkg::SAMPLE_W-1:0] sample,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [13:0]                      frame_number,
	output logic [25:0]                      magnitude_sum,
	output logic [15:0]                      peak_to_peak,
	output logic [40:0]                      frame_variance,
	output logic                             segment_ready,
	output logic [13:0]                      segment_first,
	output logic [13:0]                      segment_end
);
	import fvs_pkg::*;

	fvs_cmd_t  cmd;
	fvs_stat_t stat;

	fvs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	fvs_dp #(.MAX_FRAME(MAX_FRAME)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample         (sample),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.frame_number   (frame_number),
		.magnitude_sum  (magnitude_sum),
		.peak_to_peak   (peak_to_peak),
		.frame_variance (frame_variance),
		.segment_ready  (segment_ready),
		.segment_first  (segment_first),
		.segment_end    (segment_end)
	);
endmodule

// File: rtl/fvs_checker.sv
// Port-level checks for the frame variance voice segmenter, bound to the top.
// No dependencies.
module fvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_valid,
	input logic        sample_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic        segment_ready,
	input logic [13:0] segment_first,
	input logic [13:0] segment_end
);
	// a held beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// no segment reported means zero indices
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !segment_ready |-> segment_first == 14'd0 && segment_end == 14'd0)
		else $error("segment indices set without segment_ready");

	// input reopens only when a frame result has just been loaded
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_stall) |-> result_valid)
		else $error("sample input reopened without a result");
endmodule

bind frame_variance_voice_segmenter fvs_checker u_fvs_checker (.*);
